FILE: rtl/core/tcss_pkg.sv
// Shared types and constants of the threshold crossing slope statistics unit.
// Used by tcss_div and threshold_crossing_slope_stats_unit; no dependencies.
package tcss_pkg;

    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 96;

    localparam int SUM_W  = 56;
    localparam int CNT_W  = 24;
    localparam int TCNT_W = 16;
    localparam int PSUM_W = 40;
    localparam int TRAJ_W = 21;
    localparam int PREF_W = 17;

    localparam int DEN_W  = 33;
    localparam int QUOT_W = 32;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_TRAJ_DEF  = 1048576;

    localparam logic [PREF_W-1:0] PREF_ONE  = PREF_W'(65536);
    localparam logic [QUOT_W-1:0] SLOPE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_WELL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_WELL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL   = 2'd2;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } div_sts_t;

endpackage

FILE: rtl/core/threshold_crossing_slope_stats_unit.sv
// Top level of the threshold crossing slope statistics unit: sequencer,
// accumulators and output register around one shared divider.
// Depends on tcss_pkg and tcss_div.
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_wr_en          cfg_index, cfg_wr_data
//  s_       in   s_tvalid/s_tready  s_tdata, s_tlast, s_tuser
//  m_       out  m_tvalid/m_tready  m_tdata, m_tuser
//
// A sample without a crossing passes through check and close; a crossing adds
// the slope division, a tunnelling trajectory close a division for 1/crossings,
// and a set end the mean, the averaged prefactor and the output register.
// All of it runs through the one radix-2 divider, one quotient bit a cycle;
// a division that saturates ends in the cycle after its start.
// Reset is synchronous, active low; all accumulators clear at once.
// A result waiting on m_ does not stop input until the next set end.
module threshold_crossing_slope_stats_unit #(
    parameter int FRAC_BITS        = tcss_pkg::FRAC_BITS_DEF,
    parameter int MAX_TRAJ_PER_SET = tcss_pkg::MAX_TRAJ_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tcss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcss_pkg::DATA_W-1:0]         cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_time, sample_value
    input  logic [tcss_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    // first_of_traj, end_of_set
    input  logic [tcss_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean_slope, prefactor, crossing_total, trajectory_total, zero fill
    output logic [tcss_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // no_crossings
    output logic                                m_tuser
);

    localparam int DATA_W      = tcss_pkg::DATA_W;
    localparam int DEN_W       = tcss_pkg::DEN_W;
    localparam int SUM_W       = tcss_pkg::SUM_W;
    localparam int CNT_W       = tcss_pkg::CNT_W;
    localparam int TCNT_W      = tcss_pkg::TCNT_W;
    localparam int PSUM_W      = tcss_pkg::PSUM_W;
    localparam int TRAJ_W      = tcss_pkg::TRAJ_W;
    localparam int PREF_W      = tcss_pkg::PREF_W;
    localparam int QUOT_W      = tcss_pkg::QUOT_W;
    localparam int OUT_W       = tcss_pkg::OUT_TDATA_W;
    localparam int SLOPE_NUM_W = DEN_W + FRAC_BITS;
    localparam int NUM_W       = (SLOPE_NUM_W > SUM_W) ? SLOPE_NUM_W : SUM_W;
    localparam int TRAJ_MAXCNT = (1 << TRAJ_W) - 1;
    localparam int TRAJ_LIMIT  = (MAX_TRAJ_PER_SET > TRAJ_MAXCNT) ? TRAJ_MAXCNT
                                                                  : MAX_TRAJ_PER_SET;
    localparam int PREF_LO     = QUOT_W;
    localparam int PAD_W       = OUT_W - QUOT_W - PREF_W - CNT_W - TRAJ_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SLOPE_GO,
        ST_SLOPE_WAIT,
        ST_CLOSE,
        ST_PREF_WAIT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    state_t                    state_reg;

    logic signed [DATA_W-1:0]  lower_well_reg;
    logic signed [DATA_W-1:0]  upper_well_reg;
    logic signed [DATA_W-1:0]  critical_reg;

    logic signed [DATA_W-1:0]  prev_time_reg;
    logic signed [DATA_W-1:0]  prev_value_reg;
    logic signed [DATA_W-1:0]  start_value_reg;
    logic [TCNT_W-1:0]         traj_crossings_reg;
    logic [SUM_W-1:0]          slope_sum_reg;
    logic [CNT_W-1:0]          crossing_count_reg;
    logic [PSUM_W-1:0]         prefactor_sum_reg;
    logic [TRAJ_W-1:0]         traj_count_reg;

    logic signed [DATA_W-1:0]  t_reg;
    logic signed [DATA_W-1:0]  v_reg;
    logic                      first_reg;
    logic                      last_reg;
    logic                      eos_reg;
    logic [DEN_W-1:0]          adv_reg;
    logic [DEN_W-1:0]          adt_reg;
    logic [QUOT_W-1:0]         res_mean_reg;
    logic [PREF_W-1:0]         res_pref_reg;
    logic                      res_none_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;
    logic                      m_tuser_reg;

    logic signed [DEN_W-1:0]   dv_a;
    logic signed [DEN_W-1:0]   dv_b;
    logic signed [DEN_W-1:0]   dt_a;
    logic signed [DEN_W-1:0]   dt_b;
    logic                      crossing;
    logic                      tunnel;
    logic                      closing;
    logic                      traj_room;
    logic [QUOT_W-1:0]         slope;
    logic [SUM_W:0]            slope_sum_ext;
    logic [PSUM_W:0]           pref_sum_ext;
    logic [PREF_W-1:0]         pref_avg;
    logic                      out_free;

    tcss_pkg::div_ctl_t        div_ctl;
    tcss_pkg::div_sts_t        div_sts;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [QUOT_W-1:0]         div_quot;

    tcss_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quot    (div_quot)
    );

    assign dv_a = DEN_W'(v_reg) - DEN_W'(prev_value_reg);
    assign dv_b = DEN_W'(prev_value_reg) - DEN_W'(v_reg);
    assign dt_a = DEN_W'(t_reg) - DEN_W'(prev_time_reg);
    assign dt_b = DEN_W'(prev_time_reg) - DEN_W'(t_reg);

    assign crossing = ((v_reg > critical_reg) && (prev_value_reg < critical_reg)) ||
                      ((v_reg < critical_reg) && (prev_value_reg > critical_reg));

    assign tunnel = !(((start_value_reg <= lower_well_reg) && (v_reg <= lower_well_reg)) ||
                      ((start_value_reg >= upper_well_reg) && (v_reg >= upper_well_reg)));

    assign closing   = last_reg || eos_reg;
    assign traj_room = traj_count_reg < TRAJ_W'(TRAJ_LIMIT);
    assign slope     = div_sts.sat ? tcss_pkg::SLOPE_MAX : div_quot;
    assign slope_sum_ext = {1'b0, slope_sum_reg} + (SUM_W + 1)'(slope);
    assign pref_sum_ext  = {1'b0, prefactor_sum_reg} + (PSUM_W + 1)'(div_quot);
    assign pref_avg  = (div_sts.sat || (div_quot > QUOT_W'(tcss_pkg::PREF_ONE)))
                       ? tcss_pkg::PREF_ONE : div_quot[PREF_W-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        div_ctl.start = 1'b0;
        div_num       = NUM_W'({adv_reg, {FRAC_BITS{1'b0}}});
        div_den       = adt_reg;
        unique case (state_reg)
            ST_SLOPE_GO: begin
                div_ctl.start = 1'b1;
            end
            ST_CLOSE: begin
                div_ctl.start = closing && traj_room && tunnel && (traj_crossings_reg != '0);
                div_num       = NUM_W'(tcss_pkg::PREF_ONE);
                div_den       = DEN_W'(traj_crossings_reg);
            end
            ST_MEAN: begin
                div_ctl.start = crossing_count_reg != '0;
                div_num       = NUM_W'(slope_sum_reg);
                div_den       = DEN_W'(crossing_count_reg);
            end
            ST_MEAN_WAIT: begin
                div_ctl.start = div_sts.done && (traj_count_reg != '0);
                div_num       = NUM_W'(prefactor_sum_reg);
                div_den       = DEN_W'(traj_count_reg);
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            lower_well_reg     <= '0;
            upper_well_reg     <= '0;
            critical_reg       <= '0;
            prev_time_reg      <= '0;
            prev_value_reg     <= '0;
            start_value_reg    <= '0;
            traj_crossings_reg <= '0;
            slope_sum_reg      <= '0;
            crossing_count_reg <= '0;
            prefactor_sum_reg  <= '0;
            traj_count_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tcss_pkg::CFG_LOWER_WELL: lower_well_reg <= cfg_wr_data;
                    tcss_pkg::CFG_UPPER_WELL: upper_well_reg <= cfg_wr_data;
                    tcss_pkg::CFG_CRITICAL:   critical_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    prev_time_reg  <= t_reg;
                    prev_value_reg <= v_reg;
                    if (first_reg) begin
                        start_value_reg    <= v_reg;
                        traj_crossings_reg <= '0;
                        state_reg          <= ST_CLOSE;
                    end else if (crossing) begin
                        state_reg <= ST_SLOPE_GO;
                    end else begin
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_SLOPE_GO: begin
                    state_reg <= ST_SLOPE_WAIT;
                end
                ST_SLOPE_WAIT: begin
                    if (div_sts.done) begin
                        if (traj_crossings_reg != '1) begin
                            traj_crossings_reg <= traj_crossings_reg + 1'b1;
                        end
                        if (crossing_count_reg != '1) begin
                            crossing_count_reg <= crossing_count_reg + 1'b1;
                            slope_sum_reg      <= slope_sum_ext[SUM_W] ? '1
                                                  : slope_sum_ext[SUM_W-1:0];
                        end
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE: begin
                    if (closing) begin
                        traj_crossings_reg <= '0;
                        if (traj_room) begin
                            traj_count_reg <= traj_count_reg + 1'b1;
                        end
                        if (div_ctl.start) begin
                            state_reg <= ST_PREF_WAIT;
                        end else if (eos_reg) begin
                            state_reg <= ST_MEAN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PREF_WAIT: begin
                    if (div_sts.done) begin
                        prefactor_sum_reg <= pref_sum_ext[PSUM_W] ? '1
                                             : pref_sum_ext[PSUM_W-1:0];
                        state_reg <= eos_reg ? ST_MEAN : ST_IDLE;
                    end
                end
                ST_MEAN: begin
                    state_reg <= div_ctl.start ? ST_MEAN_WAIT : ST_OUT;
                end
                ST_MEAN_WAIT: begin
                    if (div_sts.done) begin
                        state_reg <= div_ctl.start ? ST_AVG_WAIT : ST_OUT;
                    end
                end
                ST_AVG_WAIT: begin
                    if (div_sts.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        slope_sum_reg      <= '0;
                        crossing_count_reg <= '0;
                        prefactor_sum_reg  <= '0;
                        traj_count_reg     <= '0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            t_reg     <= s_tdata[DATA_W-1:0];
            v_reg     <= s_tdata[2*DATA_W-1:DATA_W];
            first_reg <= s_tuser[0];
            last_reg  <= s_tlast;
            eos_reg   <= s_tuser[1];
        end
        if (state_reg == ST_CHECK) begin
            adv_reg <= dv_a[DEN_W-1] ? dv_b : dv_a;
            adt_reg <= dt_a[DEN_W-1] ? dt_b : dt_a;
        end
        if (state_reg == ST_MEAN) begin
            res_none_reg <= crossing_count_reg == '0;
            res_mean_reg <= '0;
            res_pref_reg <= '0;
        end
        if (state_reg == ST_MEAN_WAIT && div_sts.done) begin
            res_mean_reg <= slope;
        end
        if (state_reg == ST_AVG_WAIT && div_sts.done) begin
            res_pref_reg <= pref_avg;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tuser_reg <= res_none_reg;
            if (res_none_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {{PAD_W{1'b0}}, traj_count_reg, crossing_count_reg,
                                res_pref_reg, res_mean_reg};
            end
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == ST_SLOPE_WAIT || state_reg == ST_PREF_WAIT ||
                          state_reg == ST_MEAN_WAIT || state_reg == ST_AVG_WAIT))
        else $error("divider finished outside a wait state");

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_sts.busy)
        else $error("input open while divider busy");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("set without crossings carries non-zero data");

    a_pref_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PREF_LO+PREF_W-1:PREF_LO] <= tcss_pkg::PREF_ONE))
        else $error("prefactor above one");

    a_traj_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        traj_count_reg <= TRAJ_W'(TRAJ_LIMIT))
        else $error("trajectory count beyond limit");

endmodule

FILE: rtl/core/tcss_div.sv
// Iterative radix-2 restoring divider, one quotient bit per cycle, with
// saturation when the quotient does not fit. Depends on tcss_pkg.
module tcss_div #(
    parameter int NUM_W = 56
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tcss_pkg::div_ctl_t              ctl,
    input  logic [NUM_W-1:0]                num,
    input  logic [tcss_pkg::DEN_W-1:0]      den,
    output tcss_pkg::div_sts_t              sts,
    output logic [tcss_pkg::QUOT_W-1:0]     quot
);

    localparam int DEN_W  = tcss_pkg::DEN_W;
    localparam int QUOT_W = tcss_pkg::QUOT_W;
    localparam int HI_W   = NUM_W - QUOT_W;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int STEP_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QUOT_W-1:0] low_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [CMP_W-1:0]  hi_ext;
    logic              start_sat;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign hi_ext    = CMP_W'(num[NUM_W-1:QUOT_W]);
    assign start_sat = hi_ext >= CMP_W'(den);
    assign trial     = {rem_reg, low_reg[QUOT_W-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};
    assign rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg) begin
                sat_reg <= start_sat;
                if (start_sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= STEP_W'(QUOT_W - 1);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start && !busy_reg) begin
            rem_reg <= DEN_W'(hi_ext);
            low_reg <= num[QUOT_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.sat  = sat_reg;
    assign quot     = quot_reg;

endmodule
